FILE: hw/rtl/oahtq_pkg.sv
`default_nettype none

package oahtq_pkg;

    // Table geometry: slot count is a power of two so the home slot is the low key bits
    localparam int SLOT_W      = 4;
    localparam int TABLE_SIZE  = 1 << SLOT_W;
    localparam int PROBE_LIMIT = 32;
    localparam int H_W         = $clog2(PROBE_LIMIT + 1);
    localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;

    // Operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Result codes
    localparam logic [2:0] RES_INSERTED  = 3'd0;
    localparam logic [2:0] RES_UPDATED   = 3'd1;
    localparam logic [2:0] RES_FULL      = 3'd2;
    localparam logic [2:0] RES_REMOVED   = 3'd3;
    localparam logic [2:0] RES_NOT_FOUND = 3'd4;
    localparam logic [2:0] RES_READ      = 3'd5;

    // Slot states
    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_DELETED  = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [SLOT_W-1:0]       slot_index;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic [SLOT_W-1:0]       slot;
        logic                    slot_occupied;
        logic [KEY_W-1:0]        read_key;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        entry_total;
    } t_out;

endpackage

`default_nettype wire

FILE: hw/rtl/oahtq_ram.sv
`default_nettype none

module oahtq_ram #(
    parameter int  WIDTH = 63,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/open_address_hash_table_quadratic_core.sv
`default_nettype none

// Hash table of 16 key/value slots with quadratic probing. An item is taken when start
// is high and busy is low; busy stays high from the cycle after acceptance until the
// last slot of the walk has been examined. The result is registered into o_result in
// the cycle that o_done is high for a single cycle, and o_result holds until the next
// result. A read-slot item examines only its addressed slot; insert and remove examine
// one slot per cycle through the single key/value RAM read port and the shared probe
// adder. The walk lands on the home slot again after its 31st step, so at most 31
// slots are examined; the PROBE_LIMIT (32) cap never binds at this table size. A new
// item may be started in the same cycle that o_done is high. The result cannot be
// held off.
module open_address_hash_table_quadratic_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire oahtq_pkg::t_in  i_item,
    output logic               o_done,
    output oahtq_pkg::t_out    o_result
);

    import oahtq_pkg::*;

    localparam int KV_W = KEY_W + VAL_W;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state                  r_state, n_state;
    logic [1:0]              r_mode;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [SLOT_W-1:0]       r_home;
    logic [SLOT_W-1:0]       r_pos, n_pos;
    logic [H_W-1:0]          r_h, n_h;
    logic [SLOT_W-1:0]       r_sq, n_sq;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [1:0]              r_status [TABLE_SIZE];
    t_out                    n_result;
    logic                    n_done;

    logic                    w_accept;
    logic                    w_st_we;
    logic [1:0]              w_st_val;
    logic                    w_ram_we;
    logic [SLOT_W-1:0]       w_raddr;
    logic [KV_W-1:0]         w_rdata;
    logic [KEY_W-1:0]        w_cur_key;
    logic signed [VAL_W-1:0] w_cur_val;
    logic [1:0]              w_cur_st;
    logic [SLOT_W-1:0]       w_step_pos;
    logic                    w_walk_end;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Key/value store, one entry per slot
    oahtq_ram #(
        .WIDTH (KV_W),
        .DEPTH (TABLE_SIZE)
    ) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata ({r_key, r_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cur_key = w_rdata[KV_W-1:VAL_W];
    assign w_cur_val = w_rdata[VAL_W-1:0];
    assign w_cur_st  = r_status[r_pos];

    // Shared probe unit: next slot and end-of-walk test
    assign w_step_pos = r_pos + r_sq;
    assign w_walk_end = (w_step_pos == r_home) || (r_h >= H_W'(PROBE_LIMIT));

    // Read address: first slot on accept, next probe slot while walking
    always_comb begin
        if (r_state == S_IDLE) begin
            w_raddr = (i_item.mode >= MODE_READ) ? i_item.slot_index : i_item.key[SLOT_W-1:0];
        end else begin
            w_raddr = w_step_pos;
        end
    end

    // Sequencer: examine one slot per cycle
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_h      = r_h;
        n_sq     = r_sq;
        n_count  = r_count;
        n_done   = 1'b0;
        n_result = '0;
        w_st_we  = 1'b0;
        w_st_val = ST_EMPTY;
        w_ram_we = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PROBE;
                    n_pos   = w_raddr;
                    n_h     = H_W'(1);
                    n_sq    = SLOT_W'(1);
                end
            end
            S_PROBE: begin
                // Advance the walk by default: h squared grows by 2h + 1
                n_pos = w_step_pos;
                n_h   = r_h + H_W'(1);
                n_sq  = r_sq + SLOT_W'({r_h, 1'b1});
                n_result.entry_total = r_count;
                case (r_mode)
                    MODE_INSERT: begin
                        if (w_cur_st != ST_OCCUPIED) begin
                            w_st_we  = 1'b1;
                            w_st_val = ST_OCCUPIED;
                            w_ram_we = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_result.status      = RES_INSERTED;
                            n_result.slot        = r_pos;
                            n_result.entry_total = r_count + CNT_W'(1);
                            n_done = 1'b1;
                        end else if (w_cur_key == r_key) begin
                            w_ram_we = 1'b1;
                            n_result.status = RES_UPDATED;
                            n_result.slot   = r_pos;
                            n_done = 1'b1;
                        end else if (w_walk_end) begin
                            n_result.status = RES_FULL;
                            n_result.slot   = r_home;
                            n_done = 1'b1;
                        end
                    end
                    MODE_REMOVE: begin
                        if (w_cur_st == ST_EMPTY) begin
                            n_result.status = RES_NOT_FOUND;
                            n_result.slot   = r_home;
                            n_done = 1'b1;
                        end else if (w_cur_st == ST_OCCUPIED && w_cur_key == r_key) begin
                            w_st_we  = 1'b1;
                            w_st_val = ST_DELETED;
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                            n_result.status      = RES_REMOVED;
                            n_result.slot        = r_pos;
                            n_result.entry_total = n_count;
                            n_done = 1'b1;
                        end else if (w_walk_end) begin
                            n_result.status = RES_NOT_FOUND;
                            n_result.slot   = r_home;
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                        // Read slot; mode three reads as well
                        n_result.status = RES_READ;
                        n_result.slot   = r_pos;
                        if (w_cur_st == ST_OCCUPIED) begin
                            n_result.slot_occupied = 1'b1;
                            n_result.read_key      = w_cur_key;
                            n_result.read_value    = w_cur_val;
                        end
                        n_done = 1'b1;
                    end
                endcase
                if (n_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, slot states, walk registers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_done  <= n_done;
            if (w_st_we) begin
                r_status[r_pos] <= w_st_val;
            end
        end
        if (w_accept) begin
            r_mode  <= i_item.mode;
            r_key   <= i_item.key;
            r_value <= i_item.value;
            r_home  <= i_item.key[SLOT_W-1:0];
        end
        r_pos <= n_pos;
        r_h   <= n_h;
        r_sq  <= n_sq;
        if (n_done) begin
            o_result <= n_result;
        end
    end

    // Occupancy never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SIZE))
        else $error("entry count beyond table size");

    // A result follows only a probe cycle
    a_done_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_PROBE))
        else $error("result without a probe cycle");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not raise busy");

    // Table contents change only while probing
    a_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we || w_st_we) |-> (r_state == S_PROBE))
        else $error("table written outside a probe cycle");

endmodule

`default_nettype wire
